// ===== src/mbsh_pkg.sv =====
// Package for the MurmurHash2 byte stream hash unit: constants and sequencer states.
`timescale 1ns / 1ps
`default_nettype none

package mbsh_pkg;

    localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;
    localparam logic [31:0] HASH_SEED   = 32'h0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_K1,
        ST_MIX_K2,
        ST_MIX_H,
        ST_TAIL_MUL,
        ST_FIN_MUL,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== src/murmur2_byte_stream_hash_unit.sv =====
// Top level of the MurmurHash2 (32-bit, seed 0) byte stream hash unit.
//
// Usage:
//   Input channel (in_valid / in_stall): one message byte per transfer, with
//   byte_valid, first_of_message, last_of_message and message_length.
//   first_of_message seeds the accumulator with seed ^ message_length;
//   last_of_message closes the message and yields one hash transfer.
//   A lone transfer with byte_valid 0 and both flags set is an empty message.
//   Output channel (out_valid / out_stall): hash_value, one per message.
//
// Sequence (all arithmetic goes through one shared 32x32 multiplier by m,
// sequenced by a small state machine; in_stall is high while it works):
//   byte 1..3 of a word       : taken at once, no multiply
//   byte completing a word    : k*m, then k^=k>>24 and *m, then h*m^k
//   last transfer adds        : a tail multiply if 1..3 bytes pending,
//                               then the finalize multiply, then the result.
//   Result sits in ST_OUT until taken; in_stall stays high until the
//   hash transfer completes, so a stalling receiver holds the whole block.
//
// Reset (rst_n, asynchronous, active low) clears the accumulator, the
// partial word and the sequencer; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module murmur2_byte_stream_hash_unit
    import mbsh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        first_of_message,
    input  wire logic        last_of_message,
    input  wire logic [31:0] message_length,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      hash_value
);

    state_t      state_reg, state_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [23:0] pend_reg, pend_next;
    logic [1:0]  pos_reg, pos_next;
    logic        last_reg, last_next;

    // Shared multiplier: one operand is always m, low 32 bits kept.
    logic [31:0] mul_in;
    logic [31:0] mul_out;

    // Accept-cycle view of the state after the first flag and the byte.
    logic        in_xfer;
    logic [31:0] h_first;
    logic [23:0] pend_first;
    logic [1:0]  pos_first;
    logic [23:0] pend_ins;
    logic        word_done;

    assign in_xfer = in_valid && !in_stall;

    always_comb
    begin
        case (state_reg)
            ST_MIX_K1:   mul_in = k_reg;
            ST_MIX_K2:   mul_in = k_reg ^ (k_reg >> MIX_SHIFT);
            ST_FIN_MUL:  mul_in = h_reg ^ (h_reg >> FIN_SHIFT_A);
            default:     mul_in = h_reg;
        endcase
    end

    assign mul_out = mul_in * MIX_MULT;

    always_comb
    begin
        h_first    = first_of_message ? (HASH_SEED ^ message_length) : h_reg;
        pend_first = first_of_message ? 24'd0 : pend_reg;
        pos_first  = first_of_message ? 2'd0 : pos_reg;
        pend_ins   = pend_first | (24'(data_byte) << {pos_first, 3'b000});
        word_done  = byte_valid && (pos_first == 2'd3);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (word_done)
                        state_next = ST_MIX_K1;
                    else if (last_of_message)
                    begin
                        if (byte_valid || (pos_first != 2'd0))
                            state_next = ST_TAIL_MUL;
                        else
                            state_next = ST_FIN_MUL;
                    end
                end
            end
            ST_MIX_K1:   state_next = ST_MIX_K2;
            ST_MIX_K2:   state_next = ST_MIX_H;
            ST_MIX_H:    state_next = last_reg ? ST_FIN_MUL : ST_IDLE;
            ST_TAIL_MUL: state_next = ST_FIN_MUL;
            ST_FIN_MUL:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        h_next    = h_reg;
        k_next    = k_reg;
        pend_next = pend_reg;
        pos_next  = pos_reg;
        last_next = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    last_next = last_of_message;
                    h_next    = h_first;
                    if (word_done)
                    begin
                        k_next    = {data_byte, pend_first};
                        pend_next = 24'd0;
                        pos_next  = 2'd0;
                    end
                    else if (last_of_message)
                    begin
                        // Tail bytes fold in now; the partial word is spent.
                        if (byte_valid)
                            h_next = h_first ^ {8'd0, pend_ins};
                        else if (pos_first != 2'd0)
                            h_next = h_first ^ {8'd0, pend_first};
                        pend_next = 24'd0;
                        pos_next  = 2'd0;
                    end
                    else if (byte_valid)
                    begin
                        pend_next = pend_ins;
                        pos_next  = pos_first + 2'd1;
                    end
                    else
                    begin
                        pend_next = pend_first;
                        pos_next  = pos_first;
                    end
                end
            end
            ST_MIX_K1:   k_next = mul_out;
            ST_MIX_K2:   k_next = mul_out;
            ST_MIX_H:    h_next = mul_out ^ k_reg;
            ST_TAIL_MUL: h_next = mul_out;
            ST_FIN_MUL:  h_next = mul_out;
            ST_OUT:
            begin
                if (!out_stall)
                    h_next = 32'd0;
            end
            default:     h_next = h_reg;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        out_valid  = (state_reg == ST_OUT);
        hash_value = h_reg ^ (h_reg >> FIN_SHIFT_B);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            h_reg     <= 32'd0;
            pend_reg  <= 24'd0;
            pos_reg   <= 2'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
    end

endmodule

`default_nettype wire

// ===== src/mbsh_checker.sv =====
// Port-level assertions for the hash unit and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module mbsh_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        last_of_message,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] hash_value
);

    // Stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hash_value))
        else $error("stalled hash transfer changed");

    // A pending result blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while hash pending");

    // A non-final transfer never produces a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last_of_message |=> !out_valid)
        else $error("hash emitted without last transfer");

    // Finalization keeps the input side busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_of_message |=> in_stall)
        else $error("input not stalled during finalization");

endmodule

bind murmur2_byte_stream_hash_unit mbsh_checker u_mbsh_checker (.*);

`default_nettype wire
